// File: rtl/wrs_pkg.sv
// ----------------------------------------------------------------------------
// wrs_pkg
// Shared constants for the weighted random select block.
// ----------------------------------------------------------------------------
package wrs_pkg;

	// fixed field widths of the channels
	localparam int DRAW_BITS      = 32;
	localparam int SLOT_BITS      = 3;

	// register file
	localparam int REG_COUNT      = 8;
	localparam int CFG_FIELD_BITS = 16;
	localparam int CFG_DATA_BITS  = 32;
	localparam int ADDR_BITS      = 5;
	localparam int ADDR_LSB       = 2;

	// levels of the prefix-sum tree, enough for up to eight slots
	localparam int PFX_LEVELS     = 3;

	// parameter defaults
	localparam int DEF_SLOT_COUNT  = 8;
	localparam int DEF_WEIGHT_BITS = 16;

endpackage

// File: rtl/wrs_cfg.sv
// ----------------------------------------------------------------------------
// wrs_cfg
// Weight registers on the APB-style port and the registered prefix-sum
// tree that turns them into running sums per slot.
// ----------------------------------------------------------------------------
module wrs_cfg import wrs_pkg::*; #(
	parameter int SLOT_COUNT = DEF_SLOT_COUNT,
	parameter int STORE_BITS = DEF_WEIGHT_BITS,
	parameter int SUM_BITS   = DEF_WEIGHT_BITS + 3
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [ADDR_BITS-1:0]      paddr,
	input  logic [CFG_DATA_BITS-1:0]  pwdata,
	output logic [CFG_DATA_BITS-1:0]  prdata,
	output logic [SUM_BITS-1:0]       prefix [SLOT_COUNT],
	output logic                      total_zero,
	output logic                      busy
);

	localparam int SETTLE_BITS = $clog2(PFX_LEVELS);
	localparam int REG_IDX_BITS = ADDR_BITS - ADDR_LSB;

	logic [STORE_BITS-1:0]  weight_q [REG_COUNT];
	logic [SUM_BITS-1:0]    lvl_in [PFX_LEVELS][SLOT_COUNT];
	logic [SUM_BITS-1:0]    lvl_q  [PFX_LEVELS][SLOT_COUNT];
	logic [SETTLE_BITS-1:0] settle_q;
	logic [REG_IDX_BITS-1:0] reg_idx;
	logic                   wr_en;

	assign reg_idx = paddr[ADDR_BITS-1:ADDR_LSB];
	assign wr_en   = psel && penable && pwrite;
	assign prdata  = CFG_DATA_BITS'(weight_q[reg_idx]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < REG_COUNT; r++) begin
				weight_q[r] <= '0;
			end
			settle_q <= '0;
		end else begin
			if (wr_en) begin
				weight_q[reg_idx] <= pwdata[STORE_BITS-1:0];
				// hold off draws until the new sums reach the last tree level
				settle_q <= SETTLE_BITS'(PFX_LEVELS - 1);
			end else if (settle_q != '0) begin
				settle_q <= settle_q - SETTLE_BITS'(1);
			end
		end
	end

	assign busy = (settle_q != '0);

	// Hillis-Steele prefix sum: an adder per slot at or above 2**l
	for (genvar l = 0; l < PFX_LEVELS; l++) begin : g_lvl
		for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_slot
			if (l == 0) begin : g_src0
				assign lvl_in[l][i] = SUM_BITS'(weight_q[i]);
			end else begin : g_srcn
				assign lvl_in[l][i] = lvl_q[l-1][i];
			end
			if (i >= (1 << l)) begin : g_add
				always_ff @(posedge clk or negedge arst_n) begin
					if (!arst_n) begin
						lvl_q[l][i] <= '0;
					end else begin
						lvl_q[l][i] <= lvl_in[l][i] + lvl_in[l][i - (1 << l)];
					end
				end
			end else begin : g_pass
				always_ff @(posedge clk or negedge arst_n) begin
					if (!arst_n) begin
						lvl_q[l][i] <= '0;
					end else begin
						lvl_q[l][i] <= lvl_in[l][i];
					end
				end
			end
		end
	end

	assign prefix     = lvl_q[PFX_LEVELS-1];
	assign total_zero = (lvl_q[PFX_LEVELS-1][SLOT_COUNT-1] == '0);

endmodule

// File: rtl/wrs_mod.sv
// ----------------------------------------------------------------------------
// wrs_mod
// Pipelined restoring remainder: one draw bit per stage, draw mod total.
// ----------------------------------------------------------------------------
module wrs_mod import wrs_pkg::*; #(
	parameter int SUM_BITS = DEF_WEIGHT_BITS + 3
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [DRAW_BITS-1:0] draw,
	input  logic [SUM_BITS-1:0]  total,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [SUM_BITS-1:0]  rem
);

	localparam int STEPS = DRAW_BITS;

	logic [STEPS:0]         v_s;
	logic [STEPS+1:0]       rdy;
	logic [DRAW_BITS-1:0]   dr_s  [STEPS];
	logic [SUM_BITS-1:0]    rem_s [STEPS+1];
	logic [SUM_BITS:0]      trial [STEPS];
	logic [SUM_BITS:0]      diff  [STEPS];
	logic [SUM_BITS-1:0]    nxt   [STEPS];

	// a stage may load when it is empty or its contents move on
	assign rdy[STEPS+1] = out_ready;
	for (genvar j = 0; j <= STEPS; j++) begin : g_rdy
		assign rdy[j] = !v_s[j] || rdy[j+1];
	end
	assign in_ready = rdy[0];

	// capture stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (rdy[0]) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[0] && in_valid) begin
			dr_s[0]  <= draw;
			rem_s[0] <= '0;
		end
	end

	// step stages
	for (genvar j = 1; j <= STEPS; j++) begin : g_step
		assign trial[j-1] = {rem_s[j-1], dr_s[j-1][DRAW_BITS-1]};
		assign diff[j-1]  = trial[j-1] - {1'b0, total};
		assign nxt[j-1]   = (trial[j-1] >= {1'b0, total}) ? diff[j-1][SUM_BITS-1:0]
		                                                  : trial[j-1][SUM_BITS-1:0];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j] <= 1'b0;
			end else if (rdy[j]) begin
				v_s[j] <= v_s[j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[j] && v_s[j-1]) begin
				rem_s[j] <= nxt[j-1];
			end
		end

		if (j < STEPS) begin : g_shift
			always_ff @(posedge clk) begin
				if (rdy[j] && v_s[j-1]) begin
					dr_s[j] <= {dr_s[j-1][DRAW_BITS-2:0], 1'b0};
				end
			end
		end
	end

	assign out_valid = v_s[STEPS];
	assign rem       = rem_s[STEPS];

endmodule

// File: rtl/wrs_pick.sv
// ----------------------------------------------------------------------------
// wrs_pick
// Compares the reduced draw against every running sum, then picks the
// lowest slot whose sum exceeds it and holds the result for the receiver.
// ----------------------------------------------------------------------------
module wrs_pick import wrs_pkg::*; #(
	parameter int SLOT_COUNT = DEF_SLOT_COUNT,
	parameter int SUM_BITS   = DEF_WEIGHT_BITS + 3
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [SUM_BITS-1:0]  rem,
	input  logic [SUM_BITS-1:0]  prefix [SLOT_COUNT],
	input  logic                 total_zero,
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic [SLOT_BITS-1:0] chosen_slot,
	output logic                 no_weight
);

	logic                  v_s1;
	logic [SLOT_COUNT-1:0] lt_s1;
	logic                  v_s2;
	logic [SLOT_BITS-1:0]  slot_s2;
	logic                  nw_s2;
	logic                  rdy1;
	logic                  rdy2;
	logic [SLOT_BITS-1:0]  enc;

	assign rdy2     = !v_s2 || !result_stall;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= in_valid;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				lt_s1[i] <= (rem < prefix[i]);
			end
		end
	end

	// lowest set bit wins; a zero-weight slot repeats the previous sum
	always_comb begin
		enc = '0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (lt_s1[i]) begin
				enc = SLOT_BITS'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			slot_s2 <= total_zero ? '0 : enc;
			nw_s2   <= total_zero;
		end
	end

	assign result_valid = v_s2;
	assign chosen_slot  = slot_s2;
	assign no_weight    = nw_s2;

endmodule

// File: rtl/weighted_random_select_top.sv
// ----------------------------------------------------------------------------
// weighted_random_select_top
// Roulette-wheel selection of a slot from a table of configured weights.
// ----------------------------------------------------------------------------
// Usage:
//   Weights are written over the APB-style port, one 16-bit register per slot
//   at byte address 4*slot. Each draw transaction (draw_valid / draw_stall)
//   carries one random_draw; each returns exactly one result transaction
//   (result_valid / result_stall) with chosen_slot and no_weight, in order.
//   An accepted draw passes one capture stage, 32 remainder stages (one
//   draw bit each, set by the 32-bit draw) and two selection stages on its
//   way to result_valid. Throughput is one draw per cycle while draw_stall
//   and result_stall stay low. After a weight write the new sums pass through
//   the sum tree; draw_stall stays high until the settle counter clears.
//   Reset clears all weights, so draws return slot 0 with no_weight set.
//   When the receiver stalls, the result holds and the stages behind it
//   fill; draw_stall rises only once every stage holds a transaction.
// ----------------------------------------------------------------------------
module weighted_random_select_top import wrs_pkg::*; #(
	parameter int SLOT_COUNT  = DEF_SLOT_COUNT,
	parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [ADDR_BITS-1:0]     paddr,
	input  logic [CFG_DATA_BITS-1:0] pwdata,
	output logic [CFG_DATA_BITS-1:0] prdata,
	output logic                     pready,
	input  logic                     draw_valid,
	output logic                     draw_stall,
	input  logic [DRAW_BITS-1:0]     random_draw,
	output logic                     result_valid,
	input  logic                     result_stall,
	output logic [SLOT_BITS-1:0]     chosen_slot,
	output logic                     no_weight
);

	localparam int STORE_BITS = (WEIGHT_BITS < CFG_FIELD_BITS) ? WEIGHT_BITS : CFG_FIELD_BITS;
	localparam int SUM_BITS   = STORE_BITS + $clog2(SLOT_COUNT);

	logic [SUM_BITS-1:0] prefix [SLOT_COUNT];
	logic                total_zero;
	logic                tbl_busy;
	logic                mod_in_ready;
	logic                mod_valid;
	logic                pick_ready;
	logic [SUM_BITS-1:0] rem;

	assign pready     = 1'b1;
	assign draw_stall = !mod_in_ready || tbl_busy;

	wrs_cfg #(
		.SLOT_COUNT (SLOT_COUNT),
		.STORE_BITS (STORE_BITS),
		.SUM_BITS   (SUM_BITS)
	) u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.prefix     (prefix),
		.total_zero (total_zero),
		.busy       (tbl_busy)
	);

	wrs_mod #(
		.SUM_BITS (SUM_BITS)
	) u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (draw_valid && !tbl_busy),
		.in_ready  (mod_in_ready),
		.draw      (random_draw),
		.total     (prefix[SLOT_COUNT-1]),
		.out_valid (mod_valid),
		.out_ready (pick_ready),
		.rem       (rem)
	);

	wrs_pick #(
		.SLOT_COUNT (SLOT_COUNT),
		.SUM_BITS   (SUM_BITS)
	) u_pick (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (mod_valid),
		.in_ready     (pick_ready),
		.rem          (rem),
		.prefix       (prefix),
		.total_zero   (total_zero),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.chosen_slot  (chosen_slot),
		.no_weight    (no_weight)
	);

endmodule

// File: rtl/wrs_checker.sv
// ----------------------------------------------------------------------------
// wrs_checker
// Port-level checks for the weighted random select block, bound to the top.
// ----------------------------------------------------------------------------
module wrs_checker import wrs_pkg::*; #(
	parameter int SLOT_COUNT = DEF_SLOT_COUNT
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 psel,
	input logic                 penable,
	input logic                 pwrite,
	input logic                 pready,
	input logic                 draw_stall,
	input logic                 result_valid,
	input logic                 result_stall,
	input logic [SLOT_BITS-1:0] chosen_slot,
	input logic                 no_weight
);

	// empty table always reports slot 0
	a_empty_slot0: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && no_weight |-> chosen_slot == '0)
		else $error("no_weight result with nonzero slot");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> chosen_slot <= SLOT_BITS'(SLOT_COUNT - 1))
		else $error("chosen_slot beyond slot count");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=>
			result_valid && $stable(chosen_slot) && $stable(no_weight))
		else $error("stalled result changed");

	// draws are held off while the sum tree settles after a write
	a_settle: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready |=> draw_stall)
		else $error("draw accepted right after weight write");

endmodule

bind weighted_random_select_top wrs_checker #(
	.SLOT_COUNT (SLOT_COUNT)
) u_wrs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.psel         (psel),
	.penable      (penable),
	.pwrite       (pwrite),
	.pready       (pready),
	.draw_stall   (draw_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.chosen_slot  (chosen_slot),
	.no_weight    (no_weight)
);
